>>> rtl/lkvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants of the LRU key/value cache: field widths,
// command codes, and the command/status bundles that pass between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int DEFAULT_ENTRIES = 16;
    localparam int DATA_W          = 32;
    localparam int CAP_W           = 5;

    localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
    localparam logic [DATA_W-1:0] MISS_VALUE = '1;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_SET = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture the input item, restart the walk
        logic scan;     // read one entry for the lookup
        logic choose;   // pick the target slot and the aging rule
        logic respond;  // load the result register
        logic update;   // read one entry for the rank update
        logic commit;   // set valid of the target slot, and write its key and value for a set
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic idx_last;   // walk index sits on the last entry
        logic is_set;     // held item is a set
        logic hit_found;  // lookup found the key
        logic out_free;   // result register can take a new result
    } dp_status_t;

endpackage

>>> rtl/lru_key_value_cache_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
//
//   channel  handshake              payload                    moves
//   -------  ---------------------  -------------------------  -------------
//   cfg      cfg_write_en           cfg_write_data[4:0]        capacity
//   in       in_valid / in_stall    command, lookup_key,       one request
//                                   store_value
//   out      out_valid / out_stall  hit, read_value            one get result
//
// Walks: the key, value and rank RAMs have a single read port, so the lookup
// walks every entry once; a set or a get that hits then walks every entry
// once more for the rank update, while a get that misses skips it. The next
// request is taken only once the request before it is through.
// Reset: valid bits, fill count and handshake state clear at once, capacity
// goes to 16; no RAM clearing pass, as entry data is used only when valid.
// Stalls: the result sits in an output register; the next request is taken
// while it waits, and only the next result waits behind it.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top #(
    parameter int ENTRIES = lkvc_pkg::DEFAULT_ENTRIES
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic [lkvc_pkg::CAP_W-1:0]         cfg_write_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               command,
    input  logic signed [lkvc_pkg::DATA_W-1:0] lookup_key,
    input  logic signed [lkvc_pkg::DATA_W-1:0] store_value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               hit,
    output logic signed [lkvc_pkg::DATA_W-1:0] read_value
);

    import lkvc_pkg::*;

    // command and status between the sequencer and the datapath
    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    // sequencer: takes one request, steps it through lookup and, for a set or a hit, update
    lkvc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    // storage, trackers and result register
    lkvc_datapath #(.ENTRIES(ENTRIES)) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .command        (command),
        .lookup_key     (lookup_key),
        .store_value    (store_value),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .hit            (hit),
        .read_value     (read_value),
        .cmd            (dp_cmd),
        .status         (dp_status)
    );

    // a transfer on the input side always leaves the block busy next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request taken without going busy");

    // a set never produces a result
    a_no_result_for_set: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.respond |-> !dp_status.is_set)
        else $error("result loaded for a set");

    // results load only into a free output register
    a_respond_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.respond |-> (!out_valid || !out_stall))
        else $error("result register overwritten while stalled");

    // the block is ready again right after a commit
    a_idle_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.commit |=> !in_stall)
        else $error("block still busy after commit");

endmodule

>>> rtl/lkvc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lkvc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/lkvc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_datapath
// Entry storage, lookup trackers, rank update and result register of the
// LRU key/value cache. Keys, values and ranks live in RAMs that are walked
// one entry per cycle; valid bits and the fill count are flops.
// ----------------------------------------------------------------------------
module lkvc_datapath #(
    parameter int ENTRIES = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [lkvc_pkg::CAP_W-1:0]        cfg_write_data,
    input  logic                              command,
    input  logic signed [lkvc_pkg::DATA_W-1:0] lookup_key,
    input  logic signed [lkvc_pkg::DATA_W-1:0] store_value,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic                              hit,
    output logic signed [lkvc_pkg::DATA_W-1:0] read_value,
    input  lkvc_pkg::dp_cmd_t                 cmd,
    output lkvc_pkg::dp_status_t              status
);

    import lkvc_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int UW = $clog2(ENTRIES + 1);
    localparam int CW = (UW > CAP_W) ? UW : CAP_W;
    localparam logic [IW-1:0] LAST_IDX  = IW'(ENTRIES - 1);
    localparam logic [CW-1:0] ENTRIES_C = CW'(ENTRIES);

    // configuration and fill state
    logic [CAP_W-1:0]   cap_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [UW-1:0]      used_reg;

    // held item
    logic              cmd_reg;
    logic [DATA_W-1:0] key_reg;
    logic [DATA_W-1:0] val_reg;

    // walk
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] pidx_reg;
    logic          scan_pend_reg;
    logic          upd_pend_reg;

    // lookup trackers
    logic              hit_found_reg;
    logic [IW-1:0]     hit_slot_reg;
    logic [IW-1:0]     hit_age_reg;
    logic [DATA_W-1:0] hit_val_reg;
    logic              free_found_reg;
    logic [IW-1:0]     free_slot_reg;
    logic              old_found_reg;
    logic [IW-1:0]     old_slot_reg;
    logic [IW-1:0]     old_age_reg;

    // chosen target
    logic [IW-1:0] slot_reg;
    logic [IW-1:0] ref_age_reg;
    logic          all_mode_reg;
    logic          grow_reg;

    // result
    logic              out_valid_reg;
    logic              out_hit_reg;
    logic [DATA_W-1:0] out_value_reg;

    logic [DATA_W-1:0] key_rd;
    logic [DATA_W-1:0] val_rd;
    logic [IW-1:0]     age_rd;
    logic [IW-1:0]     age_new;
    logic [CW-1:0]     cap_ext;
    logic [CW-1:0]     eff_cap;
    logic              room;
    logic              kv_wr;
    logic              key_match;

    lkvc_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES), .AW(IW)) u_key_ram (
        .clk     (clk),
        .wr_en   (kv_wr),
        .wr_addr (slot_reg),
        .wr_data (key_reg),
        .rd_addr (idx_reg),
        .rd_data (key_rd)
    );

    lkvc_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES), .AW(IW)) u_val_ram (
        .clk     (clk),
        .wr_en   (kv_wr),
        .wr_addr (slot_reg),
        .wr_data (val_reg),
        .rd_addr (idx_reg),
        .rd_data (val_rd)
    );

    lkvc_ram #(.WIDTH(IW), .DEPTH(ENTRIES), .AW(IW)) u_age_ram (
        .clk     (clk),
        .wr_en   (upd_pend_reg),
        .wr_addr (pidx_reg),
        .wr_data (age_new),
        .rd_addr (idx_reg),
        .rd_data (age_rd)
    );

    assign kv_wr = cmd.commit && (cmd_reg == CMD_SET);

    // clamp capacity into 1..ENTRIES
    always_comb
    begin
        cap_ext = CW'(cap_reg);
        if (cap_ext == '0)
        begin
            eff_cap = CW'(1);
        end
        else if (cap_ext > ENTRIES_C)
        begin
            eff_cap = ENTRIES_C;
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    assign room      = CW'(used_reg) < eff_cap;
    assign key_match = valid_reg[pidx_reg] && (key_rd == key_reg);

    // new rank of the entry read back during the update walk
    always_comb
    begin
        if (pidx_reg == slot_reg)
        begin
            age_new = '0;
        end
        else if (valid_reg[pidx_reg] && (all_mode_reg || (age_rd < ref_age_reg)))
        begin
            age_new = IW'(age_rd + 1'b1);
        end
        else
        begin
            age_new = age_rd;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            valid_reg     <= '0;
            used_reg      <= '0;
            idx_reg       <= '0;
            scan_pend_reg <= 1'b0;
            upd_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                cap_reg <= cfg_write_data;
            end

            scan_pend_reg <= cmd.scan;
            upd_pend_reg  <= cmd.update;

            if (cmd.load || cmd.choose)
            begin
                idx_reg <= '0;
            end
            else if ((cmd.scan || cmd.update) && (idx_reg != LAST_IDX))
            begin
                idx_reg <= IW'(idx_reg + 1'b1);
            end

            if (cmd.commit)
            begin
                valid_reg[slot_reg] <= 1'b1;
                if (grow_reg)
                begin
                    used_reg <= UW'(used_reg + 1'b1);
                end
            end

            if (cmd.respond)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload and trackers
    always_ff @(posedge clk)
    begin
        pidx_reg <= idx_reg;

        if (cmd.load)
        begin
            cmd_reg        <= command;
            key_reg        <= lookup_key;
            val_reg        <= store_value;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            old_found_reg  <= 1'b0;
        end
        else if (scan_pend_reg)
        begin
            if (key_match && !hit_found_reg)
            begin
                hit_found_reg <= 1'b1;
                hit_slot_reg  <= pidx_reg;
                hit_age_reg   <= age_rd;
                hit_val_reg   <= val_rd;
            end
            if (!valid_reg[pidx_reg] && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_slot_reg  <= pidx_reg;
            end
            if (valid_reg[pidx_reg] && (!old_found_reg || (age_rd > old_age_reg)))
            begin
                old_found_reg <= 1'b1;
                old_slot_reg  <= pidx_reg;
                old_age_reg   <= age_rd;
            end
        end

        if (cmd.choose)
        begin
            ref_age_reg <= hit_age_reg;
            if (hit_found_reg)
            begin
                slot_reg     <= hit_slot_reg;
                all_mode_reg <= 1'b0;
                grow_reg     <= 1'b0;
            end
            else if (room && free_found_reg)
            begin
                slot_reg     <= free_slot_reg;
                all_mode_reg <= 1'b1;
                grow_reg     <= 1'b1;
            end
            else if (old_found_reg)
            begin
                slot_reg     <= old_slot_reg;
                all_mode_reg <= 1'b1;
                grow_reg     <= 1'b0;
            end
            else
            begin
                slot_reg     <= '0;
                all_mode_reg <= 1'b1;
                grow_reg     <= 1'b1;
            end
        end

        if (cmd.respond)
        begin
            out_hit_reg   <= hit_found_reg;
            out_value_reg <= hit_found_reg ? hit_val_reg : MISS_VALUE;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hit        = out_hit_reg;
    assign read_value = out_value_reg;

    assign status.idx_last  = (idx_reg == LAST_IDX);
    assign status.is_set    = (cmd_reg == CMD_SET);
    assign status.hit_found = hit_found_reg;
    assign status.out_free  = !out_valid_reg || !out_stall;

endmodule

>>> rtl/lkvc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_ctrl
// Sequencer of the LRU key/value cache: lookup walk, target choice, result,
// rank update walk and commit.
// ----------------------------------------------------------------------------
module lkvc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  lkvc_pkg::dp_status_t status,
    output lkvc_pkg::dp_cmd_t    cmd
);

    import lkvc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SDRAIN,
        ST_CHOOSE,
        ST_RESP,
        ST_UPDATE,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_stall_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !in_stall_reg)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.idx_last)
                begin
                    state_next = ST_SDRAIN;
                end
            end
            ST_SDRAIN:
            begin
                state_next = ST_CHOOSE;
            end
            ST_CHOOSE:
            begin
                cmd.choose = 1'b1;
                state_next = status.is_set ? ST_UPDATE : ST_RESP;
            end
            ST_RESP:
            begin
                if (status.out_free)
                begin
                    cmd.respond = 1'b1;
                    state_next  = status.hit_found ? ST_UPDATE : ST_IDLE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                if (status.idx_last)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_stall_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_stall_reg <= (state_next != ST_IDLE);
        end
    end

    assign in_stall = in_stall_reg;

endmodule
